FILE: rtl/core/acs_pkg.sv
// Shared constants and types for the converter channel scanner.
`default_nettype none
package acs_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int SAMPLE_BITS  = 10;
  localparam int CH_W         = 3;
  localparam int TABLE_DEPTH  = 8;

  typedef logic [CH_W-1:0]        chan_t;
  typedef logic [SAMPLE_BITS-1:0] sample_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_ACCESS = 2'd1,
    ST_INVALID   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REQ_CONV  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2
  } req_type_t;

  typedef enum logic [1:0] {
    CFG_REF_SELECT     = 2'd0,
    CFG_WIDE_MODE      = 2'd1,
    CFG_CHANNEL_ENABLE = 2'd2
  } cfg_index_t;

  localparam logic  DATA_REG       = 1'b1;
  localparam logic [1:0] REF_FORBIDDEN = 2'd2;
  localparam logic [1:0] REF_INTERNAL  = 2'd3;

  function automatic chan_t next_chan(input chan_t ch);
    logic [CH_W:0] inc;
    inc = {1'b0, ch} + (CH_W+1)'(1);
    if (inc >= (CH_W+1)'(NUM_CHANNELS)) begin
      return '0;
    end
    return inc[CH_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/acs_req_if.sv
// Request channel: conversion events and bus accesses.
`default_nettype none
interface acs_req_if import acs_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  sample_t    sample;
  logic       reg_index;
  logic [7:0] byte_count;
  logic [7:0] write_byte;

  modport source (output valid, req_type, sample, reg_index, byte_count, write_byte,
                  input ready);
  modport sink   (input valid, req_type, sample, reg_index, byte_count, write_byte,
                  output ready);
endinterface
`default_nettype wire

FILE: rtl/core/acs_rsp_if.sv
// Response channel: status, read data and scan control.
`default_nettype none
interface acs_rsp_if import acs_pkg::*; ();
  logic       valid;
  logic       ready;
  status_t    status;
  logic [1:0] bytes_returned;
  logic [7:0] first_byte;
  logic [7:0] second_byte;
  chan_t      mux_channel;
  logic       start_conversion;

  modport source (output valid, status, bytes_returned, first_byte, second_byte,
                  mux_channel, start_conversion, input ready);
  modport sink   (input valid, status, bytes_returned, first_byte, second_byte,
                  mux_channel, start_conversion, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/adc_channel_scanner_top.sv
// Top level of the round-robin converter channel scanner.
// Each request transaction (conversion done, bus read of the sample table, or
// bus write of the read pointer) gives exactly one response transaction; a new
// request is taken every cycle while the response register is empty or being
// drained. The response is held in the single response register and appears in
// the cycle after the request is accepted; the next enabled channel is picked
// by an eight-way rotating priority encoder in the same cycle as the accept.
// Configuration writes take effect at once and must be made while no
// transaction is in flight.
`default_nettype none
module adc_channel_scanner_top import acs_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  acs_req_if.sink         req,
  acs_rsp_if.source       rsp
);

  logic [1:0]              reference_select;
  logic                    wide_mode;
  logic [7:0]              channel_enable;
  logic                    scan_started;
  chan_t                   scan_channel;
  sample_t                 sample_table [TABLE_DEPTH];
  chan_t                   read_pointer;

  logic                    accept;
  logic [NUM_CHANNELS-1:0] live_mask;
  chan_t                   pick_start;
  chan_t                   pick_chan;
  sample_t                 rd_sample;
  logic                    scan_restart;

  status_t                 status_next;
  logic [1:0]              nbytes_next;
  logic [7:0]              b0_next;
  logic [7:0]              b1_next;
  logic                    start_next;
  chan_t                   scan_channel_next;
  logic                    scan_started_next;
  chan_t                   read_pointer_next;
  logic                    table_we;

  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign live_mask = channel_enable[NUM_CHANNELS-1:0];
  assign pick_start = scan_started ? next_chan(scan_channel) : '0;
  assign rd_sample = sample_table[read_pointer];
  // enabling from nothing restarts the scan
  assign scan_restart = cfg_we && cfg_index == CFG_CHANNEL_ENABLE &&
                        channel_enable == 8'd0 && cfg_data != 8'd0;

  acs_rr_pick u_pick (
    .mask  (live_mask),
    .start (pick_start),
    .chan  (pick_chan)
  );

  always_comb begin
    status_next       = ST_OK;
    nbytes_next       = 2'd0;
    b0_next           = 8'd0;
    b1_next           = 8'd0;
    start_next        = 1'b0;
    scan_channel_next = scan_channel;
    scan_started_next = scan_started;
    read_pointer_next = read_pointer;
    table_we          = 1'b0;
    case (req.req_type)
      REQ_CONV: begin
        if (live_mask != '0) begin
          table_we          = scan_started;
          scan_started_next = 1'b1;
          scan_channel_next = pick_chan;
          start_next        = 1'b1;
        end
      end
      REQ_READ: begin
        if (req.reg_index != DATA_REG) begin
          status_next = ST_NO_ACCESS;
        end else if (req.byte_count != 8'd0) begin
          if (wide_mode) begin
            b0_next     = 8'(rd_sample >> 8);
            b1_next     = rd_sample[7:0];
            nbytes_next = 2'd2;
          end else begin
            b0_next     = rd_sample[SAMPLE_BITS-1 -: 8];
            nbytes_next = 2'd1;
          end
          read_pointer_next = next_chan(read_pointer);
        end
      end
      REQ_WRITE: begin
        if (req.byte_count == 8'd0) begin
          status_next = ST_INVALID;
        end else begin
          read_pointer_next = req.write_byte[CH_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_select <= '0;
      wide_mode        <= 1'b0;
      channel_enable   <= '0;
      scan_started     <= 1'b0;
      scan_channel     <= '0;
      read_pointer     <= '0;
      rsp.valid        <= 1'b0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        sample_table[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_REF_SELECT: begin
            reference_select <= (cfg_data[1:0] == REF_FORBIDDEN) ? REF_INTERNAL
                                                                 : cfg_data[1:0];
          end
          CFG_WIDE_MODE: begin
            wide_mode <= cfg_data[0];
          end
          CFG_CHANNEL_ENABLE: begin
            channel_enable <= cfg_data;
          end
          default: begin
          end
        endcase
      end
      if (scan_restart) begin
        scan_started <= 1'b0;
      end else if (accept) begin
        scan_started <= scan_started_next;
      end
      if (accept) begin
        scan_channel <= scan_channel_next;
        read_pointer <= read_pointer_next;
        if (table_we) begin
          sample_table[scan_channel] <= req.sample;
        end
      end
      if (accept) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status           <= status_next;
      rsp.bytes_returned   <= nbytes_next;
      rsp.first_byte       <= b0_next;
      rsp.second_byte      <= b1_next;
      rsp.mux_channel      <= scan_channel_next;
      rsp.start_conversion <= start_next;
    end
  end

  a_ref_never_two: assert property (@(posedge clk) disable iff (rst)
    reference_select != REF_FORBIDDEN)
    else $error("reference select holds the forbidden code");

  a_start_on_enabled: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.start_conversion |-> channel_enable[rsp.mux_channel])
    else $error("conversion started on a disabled channel");

  a_bytes_only_ok: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.bytes_returned != 2'd0 |-> rsp.status == ST_OK)
    else $error("read data returned with an error status");

  a_ptr_advance: assert property (@(posedge clk) disable iff (rst)
    accept && req.req_type == REQ_READ && req.reg_index == DATA_REG &&
    req.byte_count != 8'd0 |=> read_pointer == next_chan($past(read_pointer)))
    else $error("read pointer did not advance after a data read");

  a_ptr_write: assert property (@(posedge clk) disable iff (rst)
    accept && req.req_type == REQ_WRITE && req.byte_count != 8'd0
    |=> read_pointer == $past(req.write_byte[CH_W-1:0]))
    else $error("read pointer write lost");

endmodule
`default_nettype wire

FILE: rtl/core/acs_rr_pick.sv
// Rotating priority encoder: first enabled channel at or after a start point.
`default_nettype none
module acs_rr_pick import acs_pkg::*; (
  input  wire logic [NUM_CHANNELS-1:0] mask,
  input  wire chan_t                   start,
  output chan_t                        chan
);

  always_comb begin
    logic [CH_W:0] idx;
    chan_t         c;
    chan = start;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      idx = {1'b0, start} + (CH_W+1)'(i);
      if (idx >= (CH_W+1)'(NUM_CHANNELS)) begin
        idx = idx - (CH_W+1)'(NUM_CHANNELS);
      end
      c = idx[CH_W-1:0];
      if (mask[c]) begin
        chan = c;
      end
    end
  end

endmodule
`default_nettype wire
